@@ rtl/e2q_pkg.sv @@
// Shared constants, types and arithmetic helpers for the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Angle preparation stages, CORDIC stages and the sign restore stage.
  localparam int SC_LAT  = 5 + CORDIC_ITERS + 1;
  // Two product stages and the output stage follow.
  localparam int LATENCY = SC_LAT + 3;

  localparam int ANGLE_W = 16;
  localparam int CS_W    = 33;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [CS_W-1:0]    cs_t;
  typedef logic signed [15:0]        q14_t;

  // Binary angle scaling: a * 2^23 = 90 * (BASE_MUL * a) + REM_MUL * a.
  localparam logic [31:0] BASE_MUL    = 32'd93206;
  localparam logic [21:0] REM_MUL     = 22'd68;
  localparam logic [21:0] REM_BIAS    = 22'd45;
  // Reciprocal of 90 scaled by 2^30, exact for the remainder range used here.
  localparam logic [45:0] RECIP_90    = 46'd11930465;
  localparam int          RECIP_SHIFT = 30;

  localparam cs_t GAIN_Q30 = 33'sd652032874;

  localparam cs_t ATAN_BAM [ATAN_ENTRIES] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  localparam q14_t Q14_ONE = 16'sd16384;

  // Q30 times Q30, rounded half up back to Q30.
  function automatic cs_t mul_q30(input cs_t a, input cs_t b);
    logic signed [65:0] p;
    logic signed [65:0] r;
    p = 66'(a) * 66'(b);
    r = (p + 66'sd536870912) >>> 30;
    return r[CS_W-1:0];
  endfunction

  // Q30 sum to Q2.14, rounded half up and clamped to plus or minus one.
  function automatic q14_t to_q14(input logic signed [CS_W:0] v);
    logic signed [CS_W:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) begin
      return Q14_ONE;
    end else if (r < -34'sd16384) begin
      return -Q14_ONE;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/e2q_half_sincos.sv @@
// Pipelined half-angle sine and cosine: angle scaling, quadrant fold and CORDIC stages.
module e2q_half_sincos (
  input  logic           clk,
  input  logic           en,
  input  e2q_pkg::angle_t angle,
  output e2q_pkg::cs_t    sin_out,
  output e2q_pkg::cs_t    cos_out
);
  import e2q_pkg::*;

  logic [15:0] mag;
  logic        neg1;
  logic [31:0] base2;
  logic [21:0] rem2;
  logic        neg2;
  logic [31:0] base3;
  logic [15:0] quo3;
  logic        neg3;
  logic [31:0] bam4;
  logic [45:0] quo_prod;
  logic [31:0] sum3;
  logic [31:0] fold_sum;
  logic [31:0] bam_fold;
  logic        fold;

  cs_t  x_pipe [CORDIC_ITERS+1];
  cs_t  y_pipe [CORDIC_ITERS+1];
  cs_t  z_pipe [CORDIC_ITERS+1];
  logic flip_pipe [CORDIC_ITERS+1];

  // Stage one: magnitude and sign of the angle.
  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= angle[ANGLE_W-1] ? 16'(-angle) : 16'(angle);
      neg1 <= angle[ANGLE_W-1];
    end
  end

  // Stage two: whole part of the scaling and the remainder to divide by 90.
  always_ff @(posedge clk) begin
    if (en) begin
      base2 <= {16'b0, mag} * BASE_MUL;
      rem2  <= {6'b0, mag} * REM_MUL + REM_BIAS;
      neg2  <= neg1;
    end
  end

  // Stage three: remainder divided by 90 through the reciprocal.
  assign quo_prod = {24'b0, rem2} * RECIP_90;

  always_ff @(posedge clk) begin
    if (en) begin
      base3 <= base2;
      quo3  <= quo_prod[RECIP_SHIFT+15:RECIP_SHIFT];
      neg3  <= neg2;
    end
  end

  // Stage four: rounded binary angle with its sign restored, modulo a full turn.
  assign sum3 = base3 + {16'b0, quo3};

  always_ff @(posedge clk) begin
    if (en) begin
      bam4 <= neg3 ? 32'(32'd0 - sum3) : sum3;
    end
  end

  // Stage five: fold the left half plane onto the right one.
  assign fold_sum = bam4 + 32'h4000_0000;
  assign fold     = fold_sum[31];
  assign bam_fold = fold ? (bam4 ^ 32'h8000_0000) : bam4;

  always_ff @(posedge clk) begin
    if (en) begin
      x_pipe[0]    <= GAIN_Q30;
      y_pipe[0]    <= '0;
      z_pipe[0]    <= {bam_fold[31], bam_fold};
      flip_pipe[0] <= fold;
    end
  end

  // One CORDIC rotation per stage.
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    cs_t dx;
    cs_t dy;
    assign dx = y_pipe[i] >>> i;
    assign dy = x_pipe[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_pipe[i][CS_W-1]) begin
          x_pipe[i+1] <= x_pipe[i] - dx;
          y_pipe[i+1] <= y_pipe[i] + dy;
          z_pipe[i+1] <= z_pipe[i] - ATAN_BAM[i];
        end else begin
          x_pipe[i+1] <= x_pipe[i] + dx;
          y_pipe[i+1] <= y_pipe[i] - dy;
          z_pipe[i+1] <= z_pipe[i] + ATAN_BAM[i];
        end
        flip_pipe[i+1] <= flip_pipe[i];
      end
    end
  end

  // Undo the fold by negating both results.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= flip_pipe[CORDIC_ITERS] ? -x_pipe[CORDIC_ITERS] : x_pipe[CORDIC_ITERS];
      sin_out <= flip_pipe[CORDIC_ITERS] ? -y_pipe[CORDIC_ITERS] : y_pipe[CORDIC_ITERS];
    end
  end

endmodule

@@ rtl/euler_angles_to_quaternion_top.sv @@
// Top level of the Euler angle to quaternion converter: sine/cosine units, products, output.
//
// Converts pitch, yaw and roll (signed, 1/64 degree) into a unit quaternion in Q2.14.
// The design is a fully pipelined datapath that takes one angle triple per cycle and
// holds one result per stage; a transfer on the input side is taken in every cycle in
// which the output register is empty or being read. An input transfer passes through
// the angle scaling stages, one register per CORDIC rotation, the sign restore stage,
// the two multiplier stages and the rounding stage. A stall on the output side holds
// the whole pipeline.
module euler_angles_to_quaternion_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pitch_angle, yaw_angle, roll_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;

  logic [LATENCY-1:0] vld;
  logic               adv;

  cs_t sp, cp, sy, cy, sr, cr;
  cs_t cr_sp, sr_cp, cr_cp, sr_sp, sy1, cy1;
  cs_t crspsy, srcpcy, crspcy, srcpsy, crcpsy, srspcy, crcpcy, srspsy;
  q14_t quat_x, quat_y, quat_z, quat_w;

  // The whole pipeline advances when the output register is free or being read.
  assign adv      = !vld[LATENCY-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LATENCY-1];
  assign m_tdata  = {quat_w, quat_z, quat_y, quat_x};

  // Valid bits travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end

  e2q_half_sincos u_pitch (
    .clk(clk), .en(adv), .angle(s_tdata[15:0]),  .sin_out(sp), .cos_out(cp)
  );
  e2q_half_sincos u_yaw (
    .clk(clk), .en(adv), .angle(s_tdata[31:16]), .sin_out(sy), .cos_out(cy)
  );
  e2q_half_sincos u_roll (
    .clk(clk), .en(adv), .angle(s_tdata[47:32]), .sin_out(sr), .cos_out(cr)
  );

  // First products: roll terms times pitch terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      cr_sp <= mul_q30(cr, sp);
      sr_cp <= mul_q30(sr, cp);
      cr_cp <= mul_q30(cr, cp);
      sr_sp <= mul_q30(sr, sp);
      sy1   <= sy;
      cy1   <= cy;
    end
  end

  // Second products: times the yaw terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      crspsy <= mul_q30(cr_sp, sy1);
      srcpcy <= mul_q30(sr_cp, cy1);
      crspcy <= mul_q30(cr_sp, cy1);
      srcpsy <= mul_q30(sr_cp, sy1);
      crcpsy <= mul_q30(cr_cp, sy1);
      srspcy <= mul_q30(sr_sp, cy1);
      crcpcy <= mul_q30(cr_cp, cy1);
      srspsy <= mul_q30(sr_sp, sy1);
    end
  end

  // Component sums, rounded and clamped into the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      quat_x <= to_q14(34'(crspsy) - 34'(srcpcy));
      quat_y <= to_q14(34'sd0 - 34'(crspcy) - 34'(srcpsy));
      quat_z <= to_q14(34'(crcpsy) - 34'(srspcy));
      quat_w <= to_q14(34'(crcpcy) + 34'(srspsy));
    end
  end

  // Reset empties the pipeline.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // The clamp keeps X and Y within plus or minus one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (quat_x <= Q14_ONE && quat_x >= -Q14_ONE &&
                  quat_y <= Q14_ONE && quat_y >= -Q14_ONE))
    else $error("X or Y component out of range");

  // The clamp keeps Z and W within plus or minus one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (quat_z <= Q14_ONE && quat_z >= -Q14_ONE &&
                  quat_w <= Q14_ONE && quat_w >= -Q14_ONE))
    else $error("Z or W component out of range");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Euler angle to quaternion converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  localparam int NUM_RANDOM = 1250;
  localparam int TAIL_CYCLES = LATENCY + 10;

  // Laid out like m_tdata: X in the lowest bits, W in the highest.
  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;

  quat_t quat_expected[$];
  int error_count = 0;
  int hold_off_cycles = 0;
  bit stall_enable = 1'b0;

  euler_angles_to_quaternion_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // Floor shift on a 64-bit signed value; >>> on signed is already floor.
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    return fshift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // Half-angle sine and cosine in Q30 through the rotation CORDIC.
  task automatic half_angle_sincos(input logic [15:0] raw, output longint sn,
                                   output longint cs);
    longint a, n, q, x, y, z, dx, dy;
    logic [31:0] bam;
    bit flip;
    a = longint'($signed(raw));
    n = a * 64'sd4294967296;
    if (n >= 0) q = (n + 23040) / 46080;
    else q = -((-n + 23040) / 46080);
    bam = q[31:0];
    flip = ((bam + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) bam = bam - 32'h8000_0000;
    z = longint'($signed(bam));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_BAM[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_BAM[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = y;
    cs = x;
  endtask

  function automatic logic signed [15:0] round_clamp_q14(longint v);
    longint r;
    r = fshift(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic predict_quaternion(input logic [47:0] angles, output quat_t q);
    longint sp, cp, sy, cy, sr, cr;
    half_angle_sincos(angles[15:0], sp, cp);
    half_angle_sincos(angles[31:16], sy, cy);
    half_angle_sincos(angles[47:32], sr, cr);
    q.qx = round_clamp_q14(q30_product(q30_product(cr, sp), sy)
                           - q30_product(q30_product(sr, cp), cy));
    q.qy = round_clamp_q14(-q30_product(q30_product(cr, sp), cy)
                           - q30_product(q30_product(sr, cp), sy));
    q.qz = round_clamp_q14(q30_product(q30_product(cr, cp), sy)
                           - q30_product(q30_product(sr, sp), cy));
    q.qw = round_clamp_q14(q30_product(q30_product(cr, cp), cy)
                           + q30_product(q30_product(sr, sp), sy));
  endtask

  // Offer one angle triple and hold it until the transfer happens.
  task automatic send_angles(input logic [15:0] pitch, input logic [15:0] yaw,
                             input logic [15:0] roll);
    quat_t q;
    s_tdata <= {roll, yaw, pitch};
    s_tvalid <= 1'b1;
    predict_quaternion({roll, yaw, pitch}, q);
    do @(posedge clk); while (!s_tready);
    quat_expected.push_back(q);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2)) * 16'sd5760 * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (quat_expected.size() != 0) @(negedge clk);
  endtask

  // Range limits, zero, quadrant edges and patterns outside the nominal range.
  task automatic test_directed();
    logic [15:0] corner[10];
    corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760,
               16'sd11520, 16'sd17280, 16'h7fff, 16'h8000, 16'sd1};
    for (int i = 0; i < 10; i++) send_angles(corner[i], 16'd0, 16'd0);
    for (int i = 0; i < 5; i++) send_angles(16'd0, corner[i * 2 + 1], corner[i]);
    for (int i = 0; i < 5; i++) send_angles(corner[9 - i], corner[i], corner[i + 5]);
    send_angles(16'hffff, 16'hffff, 16'hffff);
    send_angles(16'h7fff, 16'h8000, 16'h7fff);
    wait_until_drained();
  endtask

  // Random triples sent in bursts with random gaps.
  task automatic test_random();
    int left, burst;
    left = NUM_RANDOM;
    stall_enable = 1'b1;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_angles(random_angle(), random_angle(), random_angle());
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end
    wait_until_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering, to fill the pipeline.
  task automatic test_backpressure();
    hold_off_cycles = 3 * LATENCY + 20;
    for (int i = 0; i < 2 * LATENCY; i++)
      send_angles(random_angle(), random_angle(), random_angle());
    wait_until_drained();
  endtask

  // Result checker on the master side.
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (quat_expected.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        error_count++;
      end else begin
        want = quat_expected.pop_front();
        if (got.qx !== want.qx) begin
          $error("quat_x expected %0d actual %0d", want.qx, got.qx); error_count++;
        end
        if (got.qy !== want.qy) begin
          $error("quat_y expected %0d actual %0d", want.qy, got.qy); error_count++;
        end
        if (got.qz !== want.qz) begin
          $error("quat_z expected %0d actual %0d", want.qz, got.qz); error_count++;
        end
        if (got.qw !== want.qw) begin
          $error("quat_w expected %0d actual %0d", want.qw, got.qw); error_count++;
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (!stall_enable) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 7) < 5);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    stall_enable = 1'b0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && quat_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/e2q_pkg.sv
rtl/e2q_half_sincos.sv
rtl/euler_angles_to_quaternion_top.sv
tb/sv/testbench.sv
